>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, trig, cons, msg)
`endif
`endif

>>> hw/rtl/ghenc_pkg.sv
package ghenc_pkg;

  localparam int COORD_W  = 32;
  localparam int STEP_W   = 6;
  localparam int HASH_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] MAX_STEP = STEP_W'(32);

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STEP_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAT_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LON_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LON_MAX = 3'd3;

  localparam logic signed [COORD_W-1:0] LAT_MIN_RST = -32'sd754974720;
  localparam logic signed [COORD_W-1:0] LAT_MAX_RST =  32'sd754974720;
  localparam logic signed [COORD_W-1:0] LON_MIN_RST = -32'sd1509949440;
  localparam logic signed [COORD_W-1:0] LON_MAX_RST =  32'sd1509949440;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat_min;
    logic signed [COORD_W-1:0] lat_max;
    logic signed [COORD_W-1:0] lon_min;
    logic signed [COORD_W-1:0] lon_max;
  } range_t;

  typedef struct packed {
    logic [HASH_W-1:0]   hash_bits;
    logic [STEP_W-1:0]   hash_step;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

>>> hw/rtl/ghenc_step.sv
module ghenc_step (
  input  logic signed [ghenc_pkg::COORD_W-1:0] lo,
  input  logic signed [ghenc_pkg::COORD_W-1:0] hi,
  input  logic signed [ghenc_pkg::COORD_W-1:0] x,
  output logic                                 upper,
  output logic signed [ghenc_pkg::COORD_W-1:0] lo_next,
  output logic signed [ghenc_pkg::COORD_W-1:0] hi_next
);
  import ghenc_pkg::*;

  logic signed [COORD_W:0]   sum;
  logic signed [COORD_W-1:0] mid;

  // floored midpoint, one extra bit keeps the sum from overflowing
  assign sum = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
  assign mid = sum[COORD_W:1];

  always_comb begin
    upper   = (x > mid);
    lo_next = upper ? mid : lo;
    hi_next = upper ? hi : mid;
  end

endmodule

>>> hw/rtl/ghenc_core.sv
`include "assert_macros.svh"
module ghenc_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ghenc_pkg::COORD_W-1:0] lat_in,
  input  logic signed [ghenc_pkg::COORD_W-1:0] lon_in,
  input  logic [ghenc_pkg::STEP_W-1:0]         step_in,
  input  ghenc_pkg::range_t                    ranges,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output ghenc_pkg::result_t                   res
);
  import ghenc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [COORD_W-1:0] lat;
  logic signed [COORD_W-1:0] lon;
  logic signed [COORD_W-1:0] lat_lo;
  logic signed [COORD_W-1:0] lat_hi;
  logic signed [COORD_W-1:0] lon_lo;
  logic signed [COORD_W-1:0] lon_hi;
  logic [HASH_W-1:0]         hash;
  logic [STEP_W-1:0]         step;
  logic [STEP_W-1:0]         count;
  logic [STATUS_W-1:0]       status;

  logic                      lat_bit;
  logic                      lon_bit;
  logic signed [COORD_W-1:0] lat_lo_next;
  logic signed [COORD_W-1:0] lat_hi_next;
  logic signed [COORD_W-1:0] lon_lo_next;
  logic signed [COORD_W-1:0] lon_hi_next;
  logic                      step_bad;
  logic                      outside;

  ghenc_step u_lat (
    .lo(lat_lo), .hi(lat_hi), .x(lat),
    .upper(lat_bit), .lo_next(lat_lo_next), .hi_next(lat_hi_next)
  );

  ghenc_step u_lon (
    .lo(lon_lo), .hi(lon_hi), .x(lon),
    .upper(lon_bit), .lo_next(lon_lo_next), .hi_next(lon_hi_next)
  );

  assign step_bad = (step == '0) || (step > MAX_STEP);
  assign outside  = (lat < lat_lo) || (lat > lat_hi) || (lon < lon_lo) || (lon > lon_hi);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = '{hash_bits: hash, hash_step: step, status: status};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CHECK;
      ST_CHECK: state_next = (step_bad || outside) ? ST_DONE : ST_RUN;
      ST_RUN:   if (count == STEP_W'(1)) state_next = ST_DONE;
      ST_DONE:  if (res_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          lat    <= lat_in;
          lon    <= lon_in;
          step   <= step_in;
          lat_lo <= ranges.lat_min;
          lat_hi <= ranges.lat_max;
          lon_lo <= ranges.lon_min;
          lon_hi <= ranges.lon_max;
          hash   <= '0;
        end
      end
      ST_CHECK: begin
        count <= step;
        if (step_bad) begin
          status <= STATUS_STEP_BAD;
        end else if (outside) begin
          status <= STATUS_OUTSIDE;
        end else begin
          status <= STATUS_OK;
        end
      end
      ST_RUN: begin
        hash   <= {hash[HASH_W-3:0], lon_bit, lat_bit};
        lat_lo <= lat_lo_next;
        lat_hi <= lat_hi_next;
        lon_lo <= lon_lo_next;
        lon_hi <= lon_hi_next;
        count  <= count - STEP_W'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_live, clk, rst, (state != ST_RUN) || (count != '0), "run with zero count")
  `ASSERT_ALWAYS(a_lat_in_box, clk, rst, (state != ST_RUN) || ((lat_lo <= lat) && (lat <= lat_hi)), "lat left its interval")
  `ASSERT_ALWAYS(a_lon_in_box, clk, rst, (state != ST_RUN) || ((lon_lo <= lon) && (lon <= lon_hi)), "lon left its interval")
  `ASSERT_NEXT(a_done_hand, clk, rst, (state == ST_DONE) && res_ready, state == ST_IDLE, "result handed over but core not idle")

endmodule

>>> hw/rtl/geohash_interleave_encoder.sv
// geohash interleave encoder
//
// input channel (s_*): one request carries a latitude, a longitude and a step
// count; it is taken when s_tvalid and s_tready are both high. s_tready is high
// only while the bisection sequencer is idle.
// output channel (m_*): one result per request, the interleaved hash and the
// echoed step count in m_tdata, the status code in m_tuser.
// configuration: cfg_we writes cfg_data into register cfg_index (0 lat_min,
// 1 lat_max, 2 lon_min, 3 lon_max); higher indexes are ignored. write only
// while no request is in flight.
// sequence: a request is loaded, then its step and range check runs, then the
// lat and lon bisection units, reused on every step, work one step per cycle
// (1 to 32 steps), and the result is handed to the output register; a rejected
// request skips the steps. one request at a time.
// stall: the output register holds a finished result while m_tready is low;
// the sequencer still takes and works on the next request, then waits in its
// done state until the output register frees up.
// reset (rst, synchronous): sequencer idle, output empty, ranges back to the
// whole globe.
module geohash_interleave_encoder (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: lat_in [31:0], lon_in [63:32], step_count [69:64], zero pad [71:70]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,
  // m_tdata: hash_bits [63:0], hash_step [69:64], zero pad [71:70]
  // m_tuser: status [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [ghenc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghenc_pkg::COORD_W-1:0]   cfg_data
);
  import ghenc_pkg::*;

  range_t  ranges;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    res_ready;

  // configuration registers, bounds inclusive
  always_ff @(posedge clk) begin
    if (rst) begin
      ranges.lat_min <= LAT_MIN_RST;
      ranges.lat_max <= LAT_MAX_RST;
      ranges.lon_min <= LON_MIN_RST;
      ranges.lon_max <= LON_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAT_MIN: ranges.lat_min <= cfg_data;
        REG_LAT_MAX: ranges.lat_max <= cfg_data;
        REG_LON_MIN: ranges.lon_min <= cfg_data;
        REG_LON_MAX: ranges.lon_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // bisection sequencer with its lat and lon step units, reused on every step
  ghenc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .lat_in   (s_tdata[31:0]),
    .lon_in   (s_tdata[63:32]),
    .step_in  (s_tdata[69:64]),
    .ranges   (ranges),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.hash_step, out_res.hash_bits};
  assign m_tuser = out_res.status;

endmodule
